// File: design/rlbw_pkg.sv
`default_nettype none

package rlbw_pkg;

  localparam int DEF_MAX_LINE_WIDTH = 2048;
  localparam int DEF_WINDOW_LINES   = 5;
  localparam int DEF_PIXEL_BITS     = 16;

  localparam int CFG_W = 12;
  localparam int PIX_W = 16;
  localparam int COL_W = 11;

  localparam int RESET_LINE_WIDTH = 2048;

  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] col;
  } issue_t;

endpackage

`default_nettype wire

// File: design/rlbw_line_ram.sv
`default_nettype none

module rlbw_line_ram #(
  parameter int DEPTH  = 2048,
  parameter int LANES  = 4,
  parameter int LANE_W = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      re_i,
  input  wire logic [ADDR_W-1:0]         addr_i,
  input  wire logic [LANES-1:0]          we_i,
  input  wire logic [LANE_W-1:0]         wdata_i,
  output logic      [LANES*LANE_W-1:0]   rdata_o
);

  // one row holds all stored lines at one column
  logic [LANES*LANE_W-1:0] mem [DEPTH];
  logic [LANES*LANE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
    for (int l = 0; l < LANES; l++) begin
      if (we_i[l]) begin
        mem[addr_i][l*LANE_W +: LANE_W] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/rlbw_ctrl.sv
`default_nettype none

module rlbw_ctrl #(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int WINDOW_LINES   = 5,
  parameter int PIXEL_BITS     = 16,
  localparam int S      = WINDOW_LINES - 1,
  localparam int ADDR_W = $clog2(MAX_LINE_WIDTH),
  localparam int ROT_W  = $clog2(S)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [rlbw_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                        pixel_valid_i,
  input  wire logic [rlbw_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic                        ready_i,
  output logic                             ram_re_o,
  output logic      [ADDR_W-1:0]           ram_addr_o,
  output logic      [S-1:0]                ram_we_o,
  output logic      [PIXEL_BITS-1:0]       ram_wdata_o,
  output rlbw_pkg::issue_t                 issue_o,
  output logic      [ROT_W-1:0]            rot_o,
  output logic      [PIXEL_BITS-1:0]       newest_o
);

  import rlbw_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE_WIDTH + 1);
  localparam int FL_W  = $clog2(S + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RST_W = (RESET_LINE_WIDTH < MAX_LINE_WIDTH) ?
                         RESET_LINE_WIDTH : MAX_LINE_WIDTH;

  logic [CNT_W-1:0]      wid_q, wid_cfg;
  logic [FL_W-1:0]       fl_q, fl_d, fl_n;
  logic [CNT_W-1:0]      fc_q, fc_d, fc_n;
  logic [CNT_W-1:0]      dr_q, dr_d, dr_n;
  logic [ROT_W-1:0]      rot_q, rot_d, rot_n;
  logic [PIXEL_BITS-1:0] dly_q [WINDOW_LINES];
  logic                  acc, fill_wr, dly_fill, steady, shift;
  logic [CMP_W-1:0]      cfg_ext;

  // effective width, clamped to [1, MAX_LINE_WIDTH]
  always_comb begin
    cfg_ext = CMP_W'(cfg_data_i);
    if (cfg_ext == '0) begin
      wid_cfg = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_LINE_WIDTH)) begin
      wid_cfg = CNT_W'(MAX_LINE_WIDTH);
    end else begin
      wid_cfg = CNT_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= CNT_W'(RST_W);
    end else if (cfg_valid_i) begin
      wid_q <= wid_cfg;
    end
  end

  always_comb begin
    acc  = pixel_valid_i && ready_i;
    fl_n = fl_q;
    fc_n = fc_q;
    if ((fl_q < FL_W'(S)) && (fc_q >= wid_q)) begin
      fl_n = fl_q + 1'b1;
      fc_n = '0;
    end
    rot_n = rot_q;
    dr_n  = dr_q;
    if (dr_q >= wid_q) begin
      rot_n = (rot_q == ROT_W'(S - 1)) ? '0 : rot_q + 1'b1;
      dr_n  = '0;
    end
    fill_wr  = fl_n < FL_W'(S);
    dly_fill = !fill_wr && (fc_n < CNT_W'(WINDOW_LINES));
    steady   = !fill_wr && !dly_fill;

    fl_d  = fl_q;
    fc_d  = fc_q;
    dr_d  = dr_q;
    rot_d = rot_q;
    if (acc) begin
      fl_d = fl_n;
      fc_d = (fill_wr || dly_fill) ? fc_n + 1'b1 : fc_n;
      if (steady) begin
        rot_d = rot_n;
        dr_d  = dr_n + 1'b1;
      end
    end

    shift       = acc && !fill_wr;
    ram_re_o    = acc && steady;
    ram_addr_o  = steady ? dr_n[ADDR_W-1:0] : fc_n[ADDR_W-1:0];
    ram_wdata_o = fill_wr ? pixel_i[PIXEL_BITS-1:0] : dly_q[0];
    for (int l = 0; l < S; l++) begin
      ram_we_o[l] = acc && ((fill_wr && (fl_n == FL_W'(l))) ||
                            (steady && (rot_n == ROT_W'(l))));
    end
    issue_o.vld = acc && steady;
    issue_o.col = COL_W'(dr_n);
    rot_o       = rot_n;
    newest_o    = dly_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_q  <= '0;
      fc_q  <= '0;
      dr_q  <= '0;
      rot_q <= '0;
    end else begin
      fl_q  <= fl_d;
      fc_q  <= fc_d;
      dr_q  <= dr_d;
      rot_q <= rot_d;
    end
  end

  // short delay row, shifted toward index 0
  always_ff @(posedge clk_i) begin
    if (shift) begin
      for (int i = 0; i < WINDOW_LINES - 1; i++) begin
        dly_q[i] <= dly_q[i+1];
      end
      dly_q[WINDOW_LINES-1] <= pixel_i[PIXEL_BITS-1:0];
    end
  end

  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q <= ROT_W'(S - 1))
    else $error("line rotation out of range");

  a_one_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ram_we_o))
    else $error("more than one line written at once");

  a_fill_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_q <= FL_W'(S))
    else $error("fill line past stored lines");

endmodule

`default_nettype wire

// File: design/rlbw_out.sv
`default_nettype none

module rlbw_out #(
  parameter int WINDOW_LINES = 5,
  parameter int PIXEL_BITS   = 16,
  localparam int S     = WINDOW_LINES - 1,
  localparam int ROT_W = $clog2(S)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rlbw_pkg::issue_t              issue_i,
  input  wire logic [ROT_W-1:0]              rot_i,
  input  wire logic [PIXEL_BITS-1:0]         newest_i,
  input  wire logic [S*PIXEL_BITS-1:0]       rdata_i,
  output logic                               s1_free_o,
  input  wire logic                          result_ready_i,
  output logic                               result_valid_o,
  output logic      [rlbw_pkg::COL_W-1:0]    column_o,
  output logic      [rlbw_pkg::PIX_W-1:0]    tap_oldest_o,
  output logic      [rlbw_pkg::PIX_W-1:0]    tap_second_o,
  output logic      [rlbw_pkg::PIX_W-1:0]    tap_third_o,
  output logic      [rlbw_pkg::PIX_W-1:0]    tap_fourth_o,
  output logic      [rlbw_pkg::PIX_W-1:0]    tap_newest_o
);

  import rlbw_pkg::*;

  localparam int K1 = (S - 1 < 1) ? S - 1 : 1;
  localparam int K2 = (S - 1 < 2) ? S - 1 : 2;
  localparam int K3 = S - 1;

  logic                  s1_v_q, s2_v_q, s2_free;
  logic [COL_W-1:0]      s1_col_q;
  logic [ROT_W-1:0]      s1_rot_q;
  logic [PIXEL_BITS-1:0] s1_new_q;
  logic [PIXEL_BITS-1:0] t0, t1, t2, t3;
  logic [COL_W-1:0]      s2_col_q;
  logic [PIX_W-1:0]      s2_t0_q, s2_t1_q, s2_t2_q, s2_t3_q, s2_t4_q;

  // pixel of logical line k (0 = oldest) from one memory row
  function automatic logic [PIXEL_BITS-1:0] pick(
    input logic [S*PIXEL_BITS-1:0] row,
    input logic [ROT_W-1:0]        r,
    input int                      k
  );
    logic [ROT_W:0]        sum;
    logic [PIXEL_BITS-1:0] val;
    sum = (ROT_W+1)'(r) + (ROT_W+1)'(k);
    if (sum >= (ROT_W+1)'(S)) begin
      sum = sum - (ROT_W+1)'(S);
    end
    val = '0;
    for (int l = 0; l < S; l++) begin
      if (sum == (ROT_W+1)'(l)) begin
        val = row[l*PIXEL_BITS +: PIXEL_BITS];
      end
    end
    return val;
  endfunction

  assign s2_free   = !s2_v_q || result_ready_i;
  assign s1_free_o = !s1_v_q || s2_free;

  always_comb begin
    t0 = pick(rdata_i, s1_rot_q, 0);
    t1 = pick(rdata_i, s1_rot_q, K1);
    t2 = pick(rdata_i, s1_rot_q, K2);
    t3 = pick(rdata_i, s1_rot_q, K3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_free_o) begin
        s1_v_q <= issue_i.vld;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.vld) begin
      s1_col_q <= issue_i.col;
      s1_rot_q <= rot_i;
      s1_new_q <= newest_i;
    end
    if (s1_v_q && s2_free) begin
      s2_col_q <= s1_col_q;
      s2_t0_q  <= PIX_W'(t0);
      s2_t1_q  <= PIX_W'(t1);
      s2_t2_q  <= PIX_W'(t2);
      s2_t3_q  <= PIX_W'(t3);
      s2_t4_q  <= PIX_W'(s1_new_q);
    end
  end

  assign result_valid_o = s2_v_q;
  assign column_o       = s2_col_q;
  assign tap_oldest_o   = s2_t0_q;
  assign tap_second_o   = s2_t1_q;
  assign tap_third_o    = s2_t2_q;
  assign tap_fourth_o   = s2_t3_q;
  assign tap_newest_o   = s2_t4_q;

  a_issue_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i.vld |-> s1_free_o)
    else $error("request issued into a busy stage");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s2_free |=> s1_v_q)
    else $error("stalled read stage dropped");

  a_s2_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s2_free |=> s2_v_q)
    else $error("result not moved to output register");

endmodule

`default_nettype wire

// File: design/raster_line_buffer_window.sv
// Steady-state pixels pass the RAM read and stage-1 registers, then stage 2.
// Throughput: one pixel per cycle unless the output stalls; the line store is
// one RAM row per column, read and partially written at the same column in
// one cycle. Fill pixels (stored lines, then delay row) produce no result.
// Reset clears counters and line rotation and sets line width to 2048 (or
// the stored depth if smaller); line store and delay row are not cleared.
`default_nettype none

module raster_line_buffer_window #(
  parameter int MAX_LINE_WIDTH = rlbw_pkg::DEF_MAX_LINE_WIDTH,
  parameter int WINDOW_LINES   = rlbw_pkg::DEF_WINDOW_LINES,
  parameter int PIXEL_BITS     = rlbw_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rlbw_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                        pixel_valid_i,
  output logic                             pixel_ready_o,
  input  wire logic [rlbw_pkg::PIX_W-1:0]  pixel_i,
  output logic                             result_valid_o,
  input  wire logic                        result_ready_i,
  output logic      [rlbw_pkg::COL_W-1:0]  column_o,
  output logic      [rlbw_pkg::PIX_W-1:0]  tap_oldest_o,
  output logic      [rlbw_pkg::PIX_W-1:0]  tap_second_o,
  output logic      [rlbw_pkg::PIX_W-1:0]  tap_third_o,
  output logic      [rlbw_pkg::PIX_W-1:0]  tap_fourth_o,
  output logic      [rlbw_pkg::PIX_W-1:0]  tap_newest_o
);

  import rlbw_pkg::*;

  localparam int S      = WINDOW_LINES - 1;
  localparam int ADDR_W = $clog2(MAX_LINE_WIDTH);
  localparam int ROT_W  = $clog2(S);

  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_addr;
  logic [S-1:0]            ram_we;
  logic [PIXEL_BITS-1:0]   ram_wdata;
  logic [S*PIXEL_BITS-1:0] ram_rdata;
  issue_t                  issue;
  logic [ROT_W-1:0]        rot;
  logic [PIXEL_BITS-1:0]   newest;
  logic                    s1_free;

  assign cfg_ready_o   = 1'b1;
  assign pixel_ready_o = s1_free;

  rlbw_ctrl #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .WINDOW_LINES   (WINDOW_LINES),
    .PIXEL_BITS     (PIXEL_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_i       (pixel_i),
    .ready_i       (s1_free),
    .ram_re_o      (ram_re),
    .ram_addr_o    (ram_addr),
    .ram_we_o      (ram_we),
    .ram_wdata_o   (ram_wdata),
    .issue_o       (issue),
    .rot_o         (rot),
    .newest_o      (newest)
  );

  rlbw_line_ram #(
    .DEPTH  (MAX_LINE_WIDTH),
    .LANES  (S),
    .LANE_W (PIXEL_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  rlbw_out #(
    .WINDOW_LINES (WINDOW_LINES),
    .PIXEL_BITS   (PIXEL_BITS)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .issue_i        (issue),
    .rot_i          (rot),
    .newest_i       (newest),
    .rdata_i        (ram_rdata),
    .s1_free_o      (s1_free),
    .result_ready_i (result_ready_i),
    .result_valid_o (result_valid_o),
    .column_o       (column_o),
    .tap_oldest_o   (tap_oldest_o),
    .tap_second_o   (tap_second_o),
    .tap_third_o    (tap_third_o),
    .tap_fourth_o   (tap_fourth_o),
    .tap_newest_o   (tap_newest_o)
  );

endmodule

`default_nettype wire
